// ===== sv/lob_pkg.sv =====
// ----------------------------------------------------------------------------
// lob_pkg
// Shared types and constants for the limit order book matcher.
// ----------------------------------------------------------------------------
package lob_pkg;

  localparam int SideDepth = 32;
  localparam int IdxW = $clog2(SideDepth);
  localparam int CntW = $clog2(SideDepth + 1);
  localparam int QtyW = 32;
  localparam int PriceW = 24;
  localparam int TimeW = 31;
  localparam int ArrW = 32;
  localparam int MaxTrades = 63;
  localparam int TradeCntW = 6;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_BAD_QTY   = 3'd1,
    ST_BAD_PRICE = 3'd2,
    ST_FULL      = 3'd3,
    ST_TRADE     = 3'd4,
    ST_DONE      = 3'd5
  } status_t;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_MATCH = 1'b1
  } cmd_t;

  typedef enum logic {
    SIDE_BUY  = 1'b0,
    SIDE_SELL = 1'b1
  } side_t;

  // classified command between front and back
  typedef struct packed {
    cmd_t              cmd;
    side_t             side;
    status_t           reject;
    logic              is_reject;
    logic [QtyW-1:0]   qty;
    logic [PriceW-1:0] price;
    logic [TimeW-1:0]  ts;
  } cmd_word_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ADD_SCAN,
    BK_SCAN,
    BK_TRADE,
    BK_EMIT
  } bk_state_t;

endpackage

// ===== sv/lob_front.sv =====
// ----------------------------------------------------------------------------
// lob_front
// Accept commands, check quantity and price, and queue them for the back end.
// ----------------------------------------------------------------------------
module lob_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_cmd,
  input  logic                      in_side,
  input  logic [lob_pkg::QtyW-1:0]  in_qty,
  input  logic [lob_pkg::PriceW-1:0] in_price,
  input  logic [lob_pkg::TimeW-1:0] in_ts,
  output logic                      q_valid,
  input  logic                      q_ready,
  output lob_pkg::cmd_word_t        q_word
);

  // two-entry queue
  lob_pkg::cmd_word_t mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  lob_pkg::cmd_word_t w;

  // classify the incoming word
  always_comb begin
    w.cmd = lob_pkg::cmd_t'(in_cmd);
    w.side = lob_pkg::side_t'(in_side);
    w.qty = in_qty;
    w.price = in_price;
    w.ts = in_ts;
    w.is_reject = 1'b0;
    w.reject = lob_pkg::ST_ADDED;
    if (w.cmd == lob_pkg::CMD_ADD) begin
      if (in_qty == '0) begin
        w.is_reject = 1'b1;
        w.reject = lob_pkg::ST_BAD_QTY;
      end else if (in_price == '0) begin
        w.is_reject = 1'b1;
        w.reject = lob_pkg::ST_BAD_PRICE;
      end
    end
  end

  assign in_ready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_word = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem[wr_ptr] <= w;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (q_valid && q_ready) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
    end
  end

endmodule

// ===== sv/lob_back.sv =====
// ----------------------------------------------------------------------------
// lob_back
// Execute adds against one side table and match runs against both, one entry per cycle.
// ----------------------------------------------------------------------------
module lob_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  lob_pkg::cmd_word_t          q_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_status,
  output logic [lob_pkg::QtyW-1:0]    out_qty,
  output logic [lob_pkg::PriceW-1:0]  out_price,
  output logic                        out_last
);

  localparam int D = lob_pkg::SideDepth;
  localparam int IW = lob_pkg::IdxW;

  // side tables
  logic [D-1:0]                bid_valid, ask_valid;
  logic [lob_pkg::PriceW-1:0]  bid_price [D];
  logic [lob_pkg::PriceW-1:0]  ask_price [D];
  logic [lob_pkg::QtyW-1:0]    bid_qty [D];
  logic [lob_pkg::QtyW-1:0]    ask_qty [D];
  logic [lob_pkg::TimeW-1:0]   bid_time [D];
  logic [lob_pkg::TimeW-1:0]   ask_time [D];
  logic [lob_pkg::ArrW-1:0]    bid_arr [D];
  logic [lob_pkg::ArrW-1:0]    ask_arr [D];
  logic [lob_pkg::ArrW-1:0]    arrival;

  lob_pkg::bk_state_t state, state_next;
  lob_pkg::cmd_word_t cur;
  logic [IW:0]      scan;
  logic [IW-1:0]    sidx;
  logic             have_b, have_a;
  logic [IW-1:0]    best_b, best_a;
  logic [lob_pkg::TradeCntW-1:0] ntrade;
  logic             have_free;
  logic [IW-1:0]    free_idx;

  // trade datapath values
  logic [lob_pkg::QtyW-1:0] bq, aq, tq;
  logic                     crosses;

  assign sidx = scan[IW-1:0];
  assign bq = bid_qty[best_b];
  assign aq = ask_qty[best_a];
  assign tq = (bq < aq) ? bq : aq;
  assign crosses = have_b && have_a && (bid_price[best_b] >= ask_price[best_a])
                   && (ntrade != lob_pkg::TradeCntW'(lob_pkg::MaxTrades));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lob_pkg::BK_IDLE: begin
        if (q_valid) begin
          if (q_word.cmd == lob_pkg::CMD_MATCH) state_next = lob_pkg::BK_SCAN;
          else if (q_word.is_reject) state_next = lob_pkg::BK_EMIT;
          else state_next = lob_pkg::BK_ADD_SCAN;
        end
      end
      lob_pkg::BK_ADD_SCAN: begin
        if (scan == (IW+1)'(D - 1)) state_next = lob_pkg::BK_EMIT;
      end
      lob_pkg::BK_SCAN: begin
        if (scan == (IW+1)'(D - 1)) state_next = lob_pkg::BK_TRADE;
      end
      lob_pkg::BK_TRADE: state_next = lob_pkg::BK_EMIT;
      lob_pkg::BK_EMIT: begin
        if (out_ready) begin
          if (cur.cmd == lob_pkg::CMD_MATCH && !out_last) state_next = lob_pkg::BK_SCAN;
          else state_next = lob_pkg::BK_IDLE;
        end
      end
      default: state_next = lob_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_ready = (state == lob_pkg::BK_IDLE);
    out_valid = (state == lob_pkg::BK_EMIT);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lob_pkg::BK_IDLE;
      bid_valid <= '0;
      ask_valid <= '0;
      arrival <= '0;
    end else begin
      state <= state_next;
      // add: commit on last scan step
      if (state == lob_pkg::BK_ADD_SCAN && scan == (IW+1)'(D - 1)) begin
        if (have_free || ((cur.side == lob_pkg::SIDE_BUY) ? !bid_valid[sidx]
                                                          : !ask_valid[sidx])) begin
          if (cur.side == lob_pkg::SIDE_BUY) bid_valid[have_free ? free_idx : sidx] <= 1'b1;
          else ask_valid[have_free ? free_idx : sidx] <= 1'b1;
          arrival <= arrival + 1'b1;
        end
      end
      // trade: drop filled orders
      if (state == lob_pkg::BK_TRADE && crosses) begin
        if (bq == tq) bid_valid[best_b] <= 1'b0;
        if (aq == tq) ask_valid[best_a] <= 1'b0;
      end
    end
  end

  // sequencing and payload
  always_ff @(posedge clk) begin
    unique case (state)
      lob_pkg::BK_IDLE: begin
        cur <= q_word;
        scan <= '0;
        have_b <= 1'b0;
        have_a <= 1'b0;
        have_free <= 1'b0;
        ntrade <= '0;
        out_status <= q_word.reject;
        out_qty <= '0;
        out_price <= '0;
        out_last <= 1'b1;
      end
      lob_pkg::BK_ADD_SCAN: begin
        logic fr;
        fr = (cur.side == lob_pkg::SIDE_BUY) ? !bid_valid[sidx] : !ask_valid[sidx];
        scan <= scan + 1'b1;
        if (fr && !have_free) begin
          have_free <= 1'b1;
          free_idx <= sidx;
        end
        if (scan == (IW+1)'(D - 1)) begin
          logic [IW-1:0] slot;
          slot = have_free ? free_idx : sidx;
          if (have_free || fr) begin
            out_status <= lob_pkg::ST_ADDED;
            if (cur.side == lob_pkg::SIDE_BUY) begin
              bid_price[slot] <= cur.price;
              bid_qty[slot] <= cur.qty;
              bid_time[slot] <= cur.ts;
              bid_arr[slot] <= arrival;
            end else begin
              ask_price[slot] <= cur.price;
              ask_qty[slot] <= cur.qty;
              ask_time[slot] <= cur.ts;
              ask_arr[slot] <= arrival;
            end
          end else begin
            out_status <= lob_pkg::ST_FULL;
          end
        end
      end
      lob_pkg::BK_SCAN: begin
        scan <= scan + 1'b1;
        // best bid: highest price, then lowest arrival
        if (bid_valid[sidx]) begin
          if (!have_b || bid_price[sidx] > bid_price[best_b] ||
              (bid_price[sidx] == bid_price[best_b] && bid_arr[sidx] < bid_arr[best_b])) begin
            best_b <= sidx;
            have_b <= 1'b1;
          end
        end
        // best ask: lowest price, then lowest arrival
        if (ask_valid[sidx]) begin
          if (!have_a || ask_price[sidx] < ask_price[best_a] ||
              (ask_price[sidx] == ask_price[best_a] && ask_arr[sidx] < ask_arr[best_a])) begin
            best_a <= sidx;
            have_a <= 1'b1;
          end
        end
      end
      lob_pkg::BK_TRADE: begin
        if (crosses) begin
          bid_qty[best_b] <= bq - tq;
          ask_qty[best_a] <= aq - tq;
          ntrade <= ntrade + 1'b1;
          out_status <= lob_pkg::ST_TRADE;
          out_qty <= tq;
          out_price <= (bid_time[best_b] > ask_time[best_a]) ? ask_price[best_a]
                                                              : bid_price[best_b];
          out_last <= 1'b0;
        end else begin
          out_status <= lob_pkg::ST_DONE;
          out_qty <= '0;
          out_price <= '0;
          out_last <= 1'b1;
        end
      end
      lob_pkg::BK_EMIT: begin
        scan <= '0;
        have_b <= 1'b0;
        have_a <= 1'b0;
      end
      default: ;
    endcase
  end

  // checks
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == lob_pkg::ST_DONE |-> out_last)
    else $error("done word without last");
  a_trade_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == lob_pkg::ST_TRADE |-> out_qty != '0 && !out_last)
    else $error("bad trade word");
  a_cap: assert property (@(posedge clk) disable iff (rst)
    ntrade <= lob_pkg::TradeCntW'(lob_pkg::MaxTrades))
    else $error("trade run over cap");

endmodule

// ===== sv/limit_order_book_matcher_core.sv =====
// ----------------------------------------------------------------------------
// limit_order_book_matcher_core
// Two-sided price/time priority order book with a matching engine.
// ----------------------------------------------------------------------------
// Input words (s_axis) carry an add or a match command; output words
// (m_axis) carry status, trade quantity and price, with tlast on the final
// word of each command. A front end checks each word and holds up to two in
// a queue; a back end runs them one at a time.
// A rejected add answers straight from the back end's idle state; a valid add
// first scans its side's table, one entry per cycle, to find the free slot. A
// match run gives each word after a scan of all 32 entries of both sides and
// then the trade step, each further word starting once the previous one is
// taken; the closing done word comes the same way.
// At most 63 trades per run. Commands run one after another.
// Reset clears the queue, the valid bits of both sides and the arrival
// counter. When m_axis_tready is low the back end holds its word and the
// front queue fills, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: side[0], quantity[32:1], price_ticks[56:33], timestamp[87:57]
  input  logic [87:0]  s_axis_tdata,
  // tuser: command
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: fill_qty[31:0], fill_px[55:32]
  output logic [55:0]  m_axis_tdata,
  // tuser: status
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  logic               q_valid, q_ready;
  lob_pkg::cmd_word_t q_word;
  logic [lob_pkg::QtyW-1:0]   o_qty;
  logic [lob_pkg::PriceW-1:0] o_price;

  lob_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_cmd(s_axis_tuser), .in_side(s_axis_tdata[0]),
    .in_qty(s_axis_tdata[32:1]), .in_price(s_axis_tdata[56:33]),
    .in_ts(s_axis_tdata[87:57]),
    .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
  );

  lob_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_status(m_axis_tuser), .out_qty(o_qty), .out_price(o_price),
    .out_last(m_axis_tlast)
  );

  assign m_axis_tdata = {o_price, o_qty};

endmodule
